// ----- rtl/sls_pkg.sv -----
package sls_pkg;

  // Request codes carried in the action field
  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_DEL_VAL  = 2'd1,
    ACT_DEL_IDX  = 2'd2,
    ACT_READ     = 2'd3
  } action_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // What every cell does on the current cycle
  typedef enum logic [1:0] {
    MODE_HOLD    = 2'd0,
    MODE_INSERT  = 2'd1,
    MODE_DEL_VAL = 2'd2,
    MODE_DEL_IDX = 2'd3
  } mode_e;

  localparam int unsigned DataW  = 32;
  localparam int unsigned PosW   = 6;
  localparam int unsigned CountW = 7;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         position;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] read_value;
    logic [CountW-1:0]       entry_count;
  } rsp_t;

  // Broadcast from the controller to the whole row of cells
  typedef struct packed {
    mode_e             mode;
    logic [DataW-1:0]  value;
    logic [PosW-1:0]   pos;
  } cell_cmd_t;

endpackage

// ----- rtl/sls_cell.sv -----
module sls_cell
  import sls_pkg::*;
#(
  parameter int unsigned Idx = 0,
  parameter int unsigned CW  = 7
) (
  input  logic             clk_i,
  input  cell_cmd_t        cmd_i,
  input  logic [CW-1:0]    count_i,
  input  logic             left_lt_i,
  input  logic [DataW-1:0] left_entry_i,
  input  logic [DataW-1:0] right_entry_i,
  output logic [DataW-1:0] entry_o,
  output logic             lt_o,
  output logic             eq_o,
  output logic [DataW-1:0] rd_o
);

  localparam int unsigned PW = (CW > PosW) ? CW : PosW;

  logic [DataW-1:0] entry_q, entry_d;
  logic             valid;
  logic             at_or_past_pos;
  logic             at_pos;

  // Entries below the count are live; the rest hold stale data
  assign valid          = CW'(Idx) < count_i;
  assign lt_o           = valid && ($signed(entry_q) < $signed(cmd_i.value));
  assign eq_o           = valid && (entry_q == cmd_i.value);
  assign at_or_past_pos = PW'(Idx) >= PW'(cmd_i.pos);
  assign at_pos         = PW'(Idx) == PW'(cmd_i.pos);
  assign rd_o           = at_pos ? entry_q : '0;
  assign entry_o        = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.mode)
      MODE_INSERT: begin
        // keep smaller entries, drop the new value at the boundary, shift the rest up
        if (!lt_o) begin
          entry_d = left_lt_i ? cmd_i.value : left_entry_i;
        end
      end
      MODE_DEL_VAL: begin
        if (!lt_o) begin
          entry_d = right_entry_i;
        end
      end
      MODE_DEL_IDX: begin
        if (at_or_past_pos) begin
          entry_d = right_entry_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- rtl/sorted_list_store_core.sv -----
// sorted_list_store_core: ordered store of up to CAPACITY signed 32-bit values.
//
// Input channel (in_valid_i / in_ready_o / in_word_i) carries one request word:
// insert a value, remove the first entry equal to a value, remove the entry at
// an index, or read the entry at an index. Output channel (out_valid_o /
// out_ready_i / out_word_o) returns one result word per request: status,
// value read (zero unless a successful read) and the entry count afterwards.
//
// The entries live in a row of cells. On an accepted request every cell
// compares its entry with the request and, in the same cycle, keeps its entry,
// takes the new value, or takes its left or right neighbor's entry.
// The result is registered and shows in the cycle after acceptance.
// Throughput: one request per cycle while results drain, set by the cell row
// update and the registered count; no stall arises from the store itself.
// A stalled receiver holds the result register; a new request is taken only
// when that register is empty or is being drained in the same cycle.
// Reset clears the count and the output valid; entry contents are left as is
// and are never read before being written.
module sorted_list_store_core
  import sls_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_word_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_word_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > PosW) ? CW : PosW;

  logic [CW-1:0]    count_q, count_d;
  logic             out_valid_q;
  rsp_t             out_q, out_d;
  logic             in_fire;
  cell_cmd_t        cmd;

  logic [DataW-1:0] entry [CAPACITY];
  logic [DataW-1:0] rd    [CAPACITY];
  logic             lt    [CAPACITY];
  logic [CAPACITY-1:0] eq;

  logic             found;
  logic             full;
  logic             pos_ok;
  logic [DataW-1:0] rd_sel;
  logic [CW+CountW-1:0] count_ext;

  // Accept when the result register is free or drains this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign found  = |eq;
  assign full   = count_q == CW'(CAPACITY);
  assign pos_ok = PW'(in_word_i.position) < PW'(count_q);

  // Gather the addressed entry; only the matching cell drives nonzero
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_sel = rd_sel | rd[i];
    end
  end

  // Decode the request into the cell command, the next count and the result
  always_comb begin
    cmd.mode  = MODE_HOLD;
    cmd.value = in_word_i.value;
    cmd.pos   = in_word_i.position;
    count_d   = count_q;
    out_d.status     = ST_OK;
    out_d.read_value = '0;
    case (action_e'(in_word_i.action))
      ACT_INSERT: begin
        if (full) begin
          out_d.status = ST_FULL;
        end else begin
          cmd.mode = MODE_INSERT;
          count_d  = count_q + CW'(1);
        end
      end
      ACT_DEL_VAL: begin
        if (found) begin
          cmd.mode = MODE_DEL_VAL;
          count_d  = count_q - CW'(1);
        end else begin
          out_d.status = ST_NOT_FOUND;
        end
      end
      ACT_DEL_IDX: begin
        if (pos_ok) begin
          cmd.mode = MODE_DEL_IDX;
          count_d  = count_q - CW'(1);
        end else begin
          out_d.status = ST_BAD_INDEX;
        end
      end
      ACT_READ: begin
        if (pos_ok) begin
          out_d.read_value = rd_sel;
        end else begin
          out_d.status = ST_BAD_INDEX;
        end
      end
      default: out_d.status = ST_OK;
    endcase
    if (!in_fire) begin
      cmd.mode = MODE_HOLD;
      count_d  = count_q;
    end
    count_ext         = {{CountW{1'b0}}, count_d};
    out_d.entry_count = count_ext[CountW-1:0];
  end

  // Row of cells; cell zero sees a virtual smaller left neighbor
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    sls_cell #(
      .Idx (g),
      .CW  (CW)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .count_i      (count_q),
      .left_lt_i    ((g == 0) ? 1'b1 : lt[(g == 0) ? 0 : g - 1]),
      .left_entry_i (entry[(g == 0) ? 0 : g - 1]),
      .right_entry_i(entry[(g == CAPACITY - 1) ? g : g + 1]),
      .entry_o      (entry[g]),
      .lt_o         (lt[g]),
      .eq_o         (eq[g]),
      .rd_o         (rd[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load on acceptance, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Count never exceeds capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // An insert into a full store leaves the count unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_word_i.action == ACT_INSERT && full) |=> count_q == $past(count_q))
    else $error("refused insert changed the count");

  // Every accepted request produces a pending result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted request lost its result");

  // Only an ok read returns a nonzero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status != ST_OK || $past(in_word_i.action) != ACT_READ)
      && $past(in_fire)) |-> out_q.read_value == '0)
    else $error("read value set on a request that reads nothing");

endmodule

// ----- test/sorted_list_store_core_tb.sv -----
module sorted_list_store_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sls_pkg::*;

  localparam int unsigned Depth       = 64;
  localparam int unsigned RandomWords = 800;
  localparam int unsigned PhaseWords  = 100;
  // The cycle limit leaves room for the slowest legal run (gap plus long stall).
  localparam int unsigned CycleLimit  = 200000;

  logic clk_i;
  logic rst_ni;
  logic in_valid  = 1'b0;
  logic in_ready;
  req_t in_word   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_word;

  sorted_list_store_core #(
    .CAPACITY(Depth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  // Shadow copy of the ordered store, advanced once per accepted request word.
  logic signed [DataW-1:0] shadow_entries [Depth];
  int unsigned             shadow_count = 0;

  req_t        request_q [$];   // request words waiting for the driver
  rsp_t        owed_rsp_q [$];  // results the block still owes, oldest first
  int unsigned error_count  = 0;
  int unsigned accept_count = 0;
  int unsigned status_tally [4];
  int unsigned cycle_count  = 0;

  // Driver and receiver bookkeeping (touched only by their own blocks)
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_cycle;
  rsp_t        expected_rsp;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Close the hole at idx: shift every later entry one slot down.
  function automatic void drop_shadow_entry(int unsigned idx);
    int unsigned i;
    for (i = idx; i + 1 < shadow_count; i++) begin
      shadow_entries[i] = shadow_entries[i + 1];
    end
    shadow_count--;
  endfunction

  // Apply one request word to the shadow store and return the result it owes.
  function automatic rsp_t update_sorted_shadow(req_t req);
    rsp_t        rsp;
    int unsigned slot;
    int unsigned i;
    logic        found;
    rsp = '0;
    rsp.status = ST_OK;
    case (action_e'(req.action))
      ACT_INSERT: begin
        if (shadow_count >= Depth) begin
          rsp.status = ST_FULL;
        end else begin
          // Land the new value before the first entry that is not smaller.
          slot = 0;
          while (slot < shadow_count && shadow_entries[slot] < $signed(req.value)) begin
            slot++;
          end
          for (i = shadow_count; i > slot; i--) begin
            shadow_entries[i] = shadow_entries[i - 1];
          end
          shadow_entries[slot] = req.value;
          shadow_count++;
        end
      end
      ACT_DEL_VAL: begin
        found = 1'b0;
        slot  = 0;
        while (!found && slot < shadow_count) begin
          if (shadow_entries[slot] == req.value) begin
            found = 1'b1;
          end else begin
            slot++;
          end
        end
        if (found) begin
          drop_shadow_entry(slot);
        end else begin
          rsp.status = ST_NOT_FOUND;
        end
      end
      ACT_DEL_IDX: begin
        if (req.position >= shadow_count) begin
          rsp.status = ST_BAD_INDEX;
        end else begin
          drop_shadow_entry(32'(req.position));
        end
      end
      default: begin
        if (req.position >= shadow_count) begin
          rsp.status = ST_BAD_INDEX;
        end else begin
          rsp.read_value = shadow_entries[req.position];
        end
      end
    endcase
    rsp.entry_count = CountW'(shadow_count);
    return rsp;
  endfunction

  // Draw one random request word. Phase 0 fills the store, phase 1 drains it,
  // phase 2 mixes everything. Bias values toward duplicates and live entries,
  // and positions toward the current count, so hits and misses both occur.
  function automatic req_t pick_request(int unsigned phase);
    req_t        req;
    int unsigned roll;
    int signed   near_zero;
    int unsigned ins_pct;
    int unsigned delv_pct;
    int unsigned deli_pct;
    case (phase)
      0:       begin ins_pct = 70; delv_pct = 10; deli_pct = 10; end
      1:       begin ins_pct = 10; delv_pct = 35; deli_pct = 35; end
      default: begin ins_pct = 30; delv_pct = 20; deli_pct = 20; end
    endcase
    req  = '0;
    roll = $urandom_range(99);
    if (roll < ins_pct) begin
      req.action = ACT_INSERT;
    end else if (roll < ins_pct + delv_pct) begin
      req.action = ACT_DEL_VAL;
    end else if (roll < ins_pct + delv_pct + deli_pct) begin
      req.action = ACT_DEL_IDX;
    end else begin
      req.action = ACT_READ;
    end

    roll = $urandom_range(99);
    if (roll < 40) begin
      near_zero = int'($urandom_range(8)) - 4;
      req.value = near_zero;
    end else if (roll < 60 && shadow_count > 0) begin
      req.value = shadow_entries[$urandom_range(shadow_count - 1)];
    end else if (roll < 70) begin
      case ($urandom_range(3))
        0:       req.value = 32'h8000_0000;
        1:       req.value = 32'h7fff_ffff;
        2:       req.value = 32'h0000_0000;
        default: req.value = 32'hffff_ffff;
      endcase
    end else begin
      req.value = $urandom;
    end

    if ($urandom_range(3) != 0) begin
      req.position = (shadow_count > 63) ? 6'd63 : PosW'($urandom_range(shadow_count));
    end else begin
      req.position = PosW'($urandom_range(63));
    end
    return req;
  endfunction

  task automatic queue_word(action_e act, logic [DataW-1:0] val, logic [PosW-1:0] pos);
    req_t req;
    req.action   = act;
    req.value    = val;
    req.position = pos;
    request_q.push_back(req);
  endtask

  task automatic check_field(string field, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
      error_count++;
    end
  endtask

  // Driver: present words from request_q in bursts of random length with
  // random gaps; hold valid and the word until the block takes it. Each
  // accepted word advances the shadow store and queues the result it owes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_word    <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_valid && in_ready) begin
        owed_rsp_q.push_back(update_sorted_shadow(in_word));
        accept_count++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          in_valid <= 1'b1;
          in_word  <= request_q.pop_front();
          burst_left--;
          if (burst_left == 0) begin
            // Close the burst; a zero gap keeps some stretches back to back.
            burst_left = $urandom_range(1, 24);
            gap_left   = $urandom_range(0, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: rotate through always ready, coin flip, mostly stalled and a
  // fixed duty pattern so stalls land on every phase of the traffic.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready   <= 1'b0;
      stall_cycle = 0;
    end else begin
      stall_cycle++;
      case ((stall_cycle / 160) % 4)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(1) == 0);
        2:       out_ready <= ($urandom_range(4) == 0);
        default: out_ready <= ((stall_cycle % 7) < 3);
      endcase
    end
  end

  // Monitor: match every taken result word against the oldest owed result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (owed_rsp_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $realtime, out_word);
        error_count++;
      end else begin
        expected_rsp = owed_rsp_q.pop_front();
        status_tally[expected_rsp.status]++;
        check_field("status", DataW'(expected_rsp.status), DataW'(out_word.status));
        check_field("read_value", expected_rsp.read_value, out_word.read_value);
        check_field("entry_count", DataW'(expected_rsp.entry_count),
                    DataW'(out_word.entry_count));
      end
    end
  end

  // Watchdog: stop a hung run.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: run did not drain within %0d cycles", $realtime, CycleLimit);
    $display("[sorted_list_store_core] ERROR");
    $finish;
  end

  initial begin
    int unsigned sent;
    for (int i = 0; i < Depth; i++) begin
      shadow_entries[i] = '0;
    end
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-store misses, extremes, duplicates, out-of-range indexes.
    queue_word(ACT_READ,    32'd0,         6'd0);
    queue_word(ACT_DEL_IDX, 32'd0,         6'd0);
    queue_word(ACT_DEL_VAL, 32'd5,         6'd0);
    queue_word(ACT_INSERT,  32'd0,         6'd0);
    queue_word(ACT_INSERT,  32'h7fff_ffff, 6'd0);
    queue_word(ACT_INSERT,  32'h8000_0000, 6'd63);
    queue_word(ACT_INSERT,  32'hffff_ffff, 6'd0);
    queue_word(ACT_INSERT,  32'd0,         6'd0);
    queue_word(ACT_INSERT,  32'h7fff_ffff, 6'd0);
    queue_word(ACT_READ,    32'd0,         6'd0);
    queue_word(ACT_READ,    32'd0,         6'd5);
    queue_word(ACT_READ,    32'd0,         6'd6);
    queue_word(ACT_READ,    32'hffff_ffff, 6'd63);
    queue_word(ACT_DEL_VAL, 32'd12345,     6'd0);
    queue_word(ACT_DEL_VAL, 32'd0,         6'd0);
    queue_word(ACT_DEL_VAL, 32'h8000_0000, 6'd0);
    queue_word(ACT_DEL_IDX, 32'd0,         6'd63);
    queue_word(ACT_DEL_IDX, 32'd0,         6'd3);
    queue_word(ACT_DEL_IDX, 32'd0,         6'd0);
    queue_word(ACT_READ,    32'd0,         6'd0);
    queue_word(ACT_INSERT,  32'h5555_5555, 6'h2a);
    queue_word(ACT_INSERT,  32'haaaa_aaaa, 6'h15);
    queue_word(ACT_READ,    32'd0,         6'h2a);
    queue_word(ACT_READ,    32'd0,         6'h15);

    // Random: keep a few words queued ahead of the driver so its own gaps
    // decide the idle pattern; fill, drain and mix phases take turns.
    sent = 0;
    while (sent < RandomWords) begin
      @(posedge clk_i);
      while (request_q.size() < 4 && sent < RandomWords) begin
        request_q.push_back(pick_request((sent / PhaseWords) % 3));
        sent++;
      end
    end

    // Drain: every word sent and every owed result seen, then watch for strays.
    while (request_q.size() != 0 || in_valid || owed_rsp_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);

    $display("covered %0d request words through fill, drain and mixed phases",
             accept_count);
    $display("statuses seen: %0d ok, %0d not found, %0d bad index, %0d full",
             status_tally[ST_OK], status_tally[ST_NOT_FOUND],
             status_tally[ST_BAD_INDEX], status_tally[ST_FULL]);
    if (error_count == 0) begin
      $display("[sorted_list_store_core] OK");
    end else begin
      $display("[sorted_list_store_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sls_pkg.sv
rtl/sls_cell.sv
rtl/sorted_list_store_core.sv
test/sorted_list_store_core_tb.sv
